[hw/rtl/round_robin_task_scheduler_top_defines.svh]
// Assertion macros shared by the scheduler RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH

// A property checked at every rising edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold outside reset.
`define RRTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/rrts_pkg.sv]
// Types and command codes for the round-robin task scheduler.
// No dependencies; used by the counter memory and the top level.
package rrts_pkg;

  // Command codes of a request.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // Status codes of a result.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_NO_TASK = 1'b1;

  // One entry of the counter memory.
  typedef struct packed {
    logic [31:0] switches;
    logic [31:0] runtime;
  } cnt_entry_t;

  // Control of the counter memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

[hw/rtl/rrts_pick.sv]
// Rotating priority encoder that selects the next running task.
// Depends on no package items; sized by the task count.
module rrts_pick #(
  parameter int N = 16,
  parameter int W = 4
) (
  input  logic [N-1:0] run_flags,
  input  logic [W-1:0] ptr,
  input  logic         ptr_valid,
  output logic         found,
  output logic [W-1:0] sel
);

  logic [W-1:0] start;
  logic [N-1:0] upper;
  logic [W-1:0] sel_upper;
  logic [W-1:0] sel_any;

  // The search begins just after the current task, or at task 0 when none is current.
  always_comb begin
    if (!ptr_valid) begin
      start = '0;
    end else if (ptr == W'(N - 1)) begin
      start = '0;
    end else begin
      start = ptr + W'(1);
    end
  end

  // Running tasks at or above the start position take priority; the rest wrap round,
  // which leaves the current task as the last one tried.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      upper[i] = run_flags[i] && (i >= int'(start));
    end
  end

  // Lowest set bit of each vector.
  always_comb begin
    sel_upper = '0;
    sel_any   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (upper[i]) begin
        sel_upper = W'(i);
      end
      if (run_flags[i]) begin
        sel_any = W'(i);
      end
    end
  end

  assign found = |run_flags;
  assign sel   = (|upper) ? sel_upper : sel_any;

endmodule

[hw/rtl/rrts_cnt_mem.sv]
// Counter memory: runtime and switch counts of every task, with registered reads.
// Depends on rrts_pkg for the entry and control types.
module rrts_cnt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrts_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  rrts_pkg::cnt_entry_t wr_data,
  output rrts_pkg::cnt_entry_t rd_data
);

  rrts_pkg::cnt_entry_t mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  rrts_pkg::cnt_entry_t rdata_r;
  logic                 rvld_r;

  // Entry valid bits: an entry never written since reset or clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, with the entry's valid bit sampled alongside.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

[hw/rtl/round_robin_task_scheduler_top.sv]
// Round-robin task scheduler, top level.
// Requests are taken only in the idle state with the result register free or being
// emptied; the execute state does the update and write back of the counters read on
// acceptance and loads the result register, so a new request waits for the last one.
// Reset (synchronous, rst_n low) stops every task, zeroes the pointer and the tick
// total and invalidates all counter entries at once; no clearing pass is needed.
module round_robin_task_scheduler_top #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_task_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [3:0]  out_current_task,
  output logic        out_current_known,
  output logic        out_switched,
  output logic        out_task_active,
  output logic [31:0] out_task_runtime,
  output logic [31:0] out_task_switches,
  output logic [31:0] out_total_ticks
);

`include "round_robin_task_scheduler_top_defines.svh"

  localparam int PTR_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  rrts_pkg::state_t     state_r, state_nxt;
  logic [NUM_TASKS-1:0] flags_r, flags_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 ptr_vld_r, ptr_vld_nxt;
  logic [31:0]          tot_r, tot_nxt;

  // Accepted request.
  logic [2:0]           cmd_r;
  logic                 in_range_r;
  logic [PTR_W-1:0]     addr_r;
  logic                 found_r;
  logic                 sw_r;

  // Result register.
  logic                 out_valid_r;
  logic                 out_status_r;
  logic [3:0]           out_cur_r;
  logic                 out_known_r;
  logic                 out_sw_r;
  logic                 out_run_r;
  logic [31:0]          out_rt_r;
  logic [31:0]          out_swc_r;
  logic [31:0]          out_tot_r;

  logic                 in_acc;
  logic                 in_range;
  logic [PTR_W+3:0]     idx_ext;
  logic [PTR_W-1:0]     idx_addr;
  logic [PTR_W-1:0]     addr_nxt;
  logic                 pick_found;
  logic [PTR_W-1:0]     pick_sel;
  logic                 sw;
  logic [PTR_W+3:0]     ptr_ext;

  rrts_pkg::mem_ctl_t   ctl;
  rrts_pkg::cnt_entry_t rd_data;
  rrts_pkg::cnt_entry_t wr_data;

  logic                 res_status;
  logic                 res_sw;
  logic                 res_run;
  logic [31:0]          res_rt;
  logic [31:0]          res_swc;

  // A new request is taken when idle and the result register is free or being emptied.
  assign in_ready = (state_r == rrts_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // Task index decoding.
  assign in_range = {28'd0, in_task_index} < 32'(NUM_TASKS);
  assign idx_ext  = {{PTR_W{1'b0}}, in_task_index};
  assign idx_addr = idx_ext[PTR_W-1:0];

  rrts_pick #(
    .N (NUM_TASKS),
    .W (PTR_W)
  ) u_pick (
    .run_flags (flags_r),
    .ptr       (ptr_r),
    .ptr_valid (ptr_vld_r),
    .found     (pick_found),
    .sel       (pick_sel)
  );

  // A switch happens when the chosen task is not the one already current.
  assign sw       = pick_found && (!ptr_vld_r || (pick_sel != ptr_r));
  assign addr_nxt = (in_cmd == rrts_pkg::CMD_TICK) ? pick_sel : idx_addr;

  rrts_cnt_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (PTR_W)
  ) u_cnt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (addr_nxt),
    .wr_addr (addr_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Counter update of the selected task.
  assign wr_data.runtime  = rd_data.runtime + 32'd1;
  assign wr_data.switches = rd_data.switches + {31'd0, sw_r};

  // Controller: read the counters on acceptance, then apply the command.
  always_comb begin
    state_nxt   = state_r;
    flags_nxt   = flags_r;
    ptr_nxt     = ptr_r;
    ptr_vld_nxt = ptr_vld_r;
    tot_nxt     = tot_r;
    ctl         = '0;
    res_status  = rrts_pkg::STAT_OK;
    res_sw      = 1'b0;
    res_run     = 1'b0;
    res_rt      = '0;
    res_swc     = '0;
    case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = rrts_pkg::ST_EXEC;
          ctl.rd_en = 1'b1;
        end
      end
      rrts_pkg::ST_EXEC: begin
        state_nxt = rrts_pkg::ST_IDLE;
        case (cmd_r)
          rrts_pkg::CMD_TICK: begin
            tot_nxt = tot_r + 32'd1;
            if (found_r) begin
              ptr_nxt     = addr_r;
              ptr_vld_nxt = 1'b1;
              ctl.wr_en   = 1'b1;
              res_sw      = sw_r;
            end
          end
          rrts_pkg::CMD_START, rrts_pkg::CMD_STOP: begin
            if (in_range_r) begin
              flags_nxt[addr_r] = (cmd_r == rrts_pkg::CMD_START);
            end else begin
              res_status = rrts_pkg::STAT_NO_TASK;
            end
          end
          rrts_pkg::CMD_READ: begin
            if (in_range_r) begin
              res_run = flags_r[addr_r];
              res_rt  = rd_data.runtime;
              res_swc = rd_data.switches;
            end else begin
              res_status = rrts_pkg::STAT_NO_TASK;
            end
          end
          rrts_pkg::CMD_CLEAR: begin
            tot_nxt     = '0;
            ptr_nxt     = '0;
            ptr_vld_nxt = 1'b0;
            ctl.clr     = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrts_pkg::ST_IDLE;
      flags_r   <= '0;
      ptr_r     <= '0;
      ptr_vld_r <= 1'b0;
      tot_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      flags_r   <= flags_nxt;
      ptr_r     <= ptr_nxt;
      ptr_vld_r <= ptr_vld_nxt;
      tot_r     <= tot_nxt;
    end
  end

  // Accepted request fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= in_cmd;
      in_range_r <= in_range;
      addr_r     <= addr_nxt;
      found_r    <= pick_found;
      sw_r       <= sw;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == rrts_pkg::ST_EXEC) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Pointer reported in four bits.
  assign ptr_ext = {4'd0, ptr_nxt};

  // Result payload, captured as the command completes.
  always_ff @(posedge clk) begin
    if (state_r == rrts_pkg::ST_EXEC) begin
      out_status_r <= res_status;
      out_cur_r    <= ptr_ext[3:0];
      out_known_r  <= ptr_vld_nxt;
      out_sw_r     <= res_sw;
      out_run_r    <= res_run;
      out_rt_r     <= res_rt;
      out_swc_r    <= res_swc;
      out_tot_r    <= tot_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_task  = out_cur_r;
  assign out_current_known = out_known_r;
  assign out_switched      = out_sw_r;
  assign out_task_active   = out_run_r;
  assign out_task_runtime  = out_rt_r;
  assign out_task_switches = out_swc_r;
  assign out_total_ticks   = out_tot_r;

  // Counter writes come only from a tick that found a running task.
  `RRTS_ASSERT(a_wr_only_tick,
    ctl.wr_en |-> (state_r == rrts_pkg::ST_EXEC) && (cmd_r == rrts_pkg::CMD_TICK) && found_r,
    "counter write outside a productive tick")
  // Reads and writes of the counter memory never share a cycle.
  `RRTS_ASSERT_NEVER(a_rd_wr_overlap, ctl.rd_en && ctl.wr_en,
    "counter read and write overlap")
  // A result appears only after a command has executed.
  `RRTS_ASSERT(a_out_after_exec,
    $rose(out_valid_r) |-> $past(state_r == rrts_pkg::ST_EXEC),
    "result without execution")
  // A tick that found a running task leaves a valid pointer.
  `RRTS_ASSERT(a_tick_sets_ptr,
    (state_r == rrts_pkg::ST_EXEC) && (cmd_r == rrts_pkg::CMD_TICK) && found_r |=> ptr_vld_r,
    "pointer not valid after tick")
  // A clear leaves the tick total at zero and no task current.
  `RRTS_ASSERT(a_clear_zeroes,
    (state_r == rrts_pkg::ST_EXEC) && (cmd_r == rrts_pkg::CMD_CLEAR)
      |=> (tot_r == 32'd0) && !ptr_vld_r,
    "clear incomplete")

endmodule
